// File: rtl/core/qcr_pkg.sv
// ----------------------------------------------------------------------------
// qcr_pkg
// Shared types and constants of the quarter circle rasterizer.
// ----------------------------------------------------------------------------
package qcr_pkg;

    localparam int RAD_W       = 6;
    localparam int OFS_W       = 7;
    localparam int ERR_W       = 12;
    localparam int FRAME_W     = 12;
    localparam int PIX_W       = 13;
    localparam int COLOR_W     = 24;
    localparam int QTR_W       = 2;
    localparam int MAX_RESULTS = 64;
    localparam int CNT_W       = $clog2(MAX_RESULTS);
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [FRAME_W-1:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [FRAME_W-1:0] FRAME_HEIGHT_RST = 12'd480;

    typedef enum logic [QTR_W-1:0] {
        QTR_NEG_X  = 2'd0,
        QTR_NEG_Y  = 2'd1,
        QTR_POS_X  = 2'd2,
        QTR_POS_Y  = 2'd3
    } quarter_t;

    typedef struct packed {
        logic load;
        logic advance;
    } walk_ctrl_t;

endpackage

// File: rtl/core/quarter_circle_rasterizer.sv
// ----------------------------------------------------------------------------
// quarter_circle_rasterizer
// The walk is loaded when the command word is accepted; each pixel is then
// computed in ST_WALK and registered into the output register. Throughput:
// one pixel per cycle while out_stall is low. An arc has n pixels (n <= 64,
// set by the walk end or the 64-pixel cap); in_stall is high for the whole arc.
// The walk unit does one circle step per pixel.
// Reset: idle, output empty, frame size 640 x 480.
// ----------------------------------------------------------------------------
module quarter_circle_rasterizer
#(
    parameter int MAX_RADIUS = 40,
    parameter int COORD_BITS = 11
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic        [qcr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic        [qcr_pkg::FRAME_W-1:0]   cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic        [COORD_BITS-1:0]         center_x,
    input  logic        [COORD_BITS-1:0]         center_y,
    input  logic        [qcr_pkg::RAD_W-1:0]     radius,
    input  logic        [qcr_pkg::QTR_W-1:0]     quarter,
    input  logic        [qcr_pkg::COLOR_W-1:0]   draw_color,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [qcr_pkg::PIX_W-1:0]     pixel_x,
    output logic signed [qcr_pkg::PIX_W-1:0]     pixel_y,
    output logic                                 visible,
    output logic        [qcr_pkg::COLOR_W-1:0]   pixel_color,
    output logic                                 last_point
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WALK = 2'b10
    } state_t;

    localparam logic [qcr_pkg::RAD_W-1:0] MAX_RAD_V = qcr_pkg::RAD_W'(MAX_RADIUS);
    localparam logic [qcr_pkg::CNT_W-1:0] CNT_LAST  =
        qcr_pkg::CNT_W'(qcr_pkg::MAX_RESULTS - 1);

    state_t                          state_reg, state_next;
    logic [qcr_pkg::FRAME_W-1:0]     fw_reg, fw_next, fh_reg, fh_next;
    logic [COORD_BITS-1:0]           cx_reg, cx_next, cy_reg, cy_next;
    qcr_pkg::quarter_t               q_reg, q_next;
    logic [qcr_pkg::COLOR_W-1:0]     color_reg, color_next;
    logic [qcr_pkg::CNT_W-1:0]       count_reg, count_next;
    logic                            ov_reg, ov_next;
    logic [qcr_pkg::PIX_W-1:0]       px_reg, px_next, py_reg, py_next;
    logic                            vis_reg, vis_next, last_reg, last_next;
    logic [qcr_pkg::COLOR_W-1:0]     ocol_reg, ocol_next;

    qcr_pkg::walk_ctrl_t             walk_ctrl;
    logic [qcr_pkg::RAD_W-1:0]       radius_sat;
    logic signed [qcr_pkg::OFS_W-1:0] offset_x, offset_y;
    logic                            step_done;
    logic [qcr_pkg::PIX_W-1:0]       plot_x, plot_y;
    logic                            plot_vis;
    logic                            accept, fire, arc_end;

    assign radius_sat = (radius > MAX_RAD_V) ? MAX_RAD_V : radius;
    assign accept     = in_valid && (state_reg == ST_IDLE);
    assign fire       = (state_reg == ST_WALK) && (!ov_reg || !out_stall);
    assign arc_end    = step_done || (count_reg == CNT_LAST);

    always_comb
    begin
        walk_ctrl.load    = accept;
        walk_ctrl.advance = fire;
    end

    qcr_walk u_walk
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (walk_ctrl),
        .radius_sat (radius_sat),
        .offset_x   (offset_x),
        .offset_y   (offset_y),
        .step_done  (step_done)
    );

    qcr_plot #(
        .COORD_BITS (COORD_BITS)
    ) u_plot
    (
        .center_x     (cx_reg),
        .center_y     (cy_reg),
        .quarter      (q_reg),
        .offset_x     (offset_x),
        .offset_y     (offset_y),
        .frame_width  (fw_reg),
        .frame_height (fh_reg),
        .pixel_x      (plot_x),
        .pixel_y      (plot_y),
        .visible      (plot_vis)
    );

    always_comb
    begin
        state_next = state_reg;
        fw_next    = fw_reg;
        fh_next    = fh_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        q_next     = q_reg;
        color_next = color_reg;
        count_next = count_reg;
        ov_next    = ov_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        vis_next   = vis_reg;
        last_next  = last_reg;
        ocol_next  = ocol_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                qcr_pkg::REG_FRAME_WIDTH:  fw_next = cfg_data;
                qcr_pkg::REG_FRAME_HEIGHT: fh_next = cfg_data;
                default:                   fw_next = fw_reg;
            endcase
        end

        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cx_next    = center_x;
                    cy_next    = center_y;
                    q_next     = qcr_pkg::quarter_t'(quarter);
                    color_next = draw_color;
                    count_next = '0;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (fire)
                begin
                    ov_next    = 1'b1;
                    px_next    = plot_x;
                    py_next    = plot_y;
                    vis_next   = plot_vis;
                    ocol_next  = color_reg;
                    last_next  = arc_end;
                    count_next = count_reg + qcr_pkg::CNT_W'(1);
                    if (arc_end)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fw_reg    <= qcr_pkg::FRAME_WIDTH_RST;
            fh_reg    <= qcr_pkg::FRAME_HEIGHT_RST;
            count_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fw_reg    <= fw_next;
            fh_reg    <= fh_next;
            count_reg <= count_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        q_reg     <= q_next;
        color_reg <= color_next;
        px_reg    <= px_next;
        py_reg    <= py_next;
        vis_reg   <= vis_next;
        last_reg  <= last_next;
        ocol_reg  <= ocol_next;
    end

    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = ov_reg;
    assign pixel_x     = px_reg;
    assign pixel_y     = py_reg;
    assign visible     = vis_reg;
    assign pixel_color = ocol_reg;
    assign last_point  = last_reg;

endmodule

// File: rtl/core/qcr_walk.sv
// ----------------------------------------------------------------------------
// qcr_walk
// Error-term circle walk: holds the offset and error, one step per advance.
// ----------------------------------------------------------------------------
module qcr_walk
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  qcr_pkg::walk_ctrl_t                 ctrl,
    input  logic        [qcr_pkg::RAD_W-1:0]    radius_sat,
    output logic signed [qcr_pkg::OFS_W-1:0]    offset_x,
    output logic signed [qcr_pkg::OFS_W-1:0]    offset_y,
    output logic                                step_done
);

    logic signed [qcr_pkg::ERR_W-1:0] err_reg, err_next;
    logic signed [qcr_pkg::OFS_W-1:0] ox_reg, ox_next;
    logic signed [qcr_pkg::OFS_W-1:0] oy_reg, oy_next;

    logic signed [qcr_pkg::ERR_W-1:0] ox_ext, oy_ext, ox1_ext, oy1_ext;
    logic signed [qcr_pkg::ERR_W-1:0] err1, err2;
    logic signed [qcr_pkg::OFS_W-1:0] ox1, oy1;
    logic                             y_step, x_step;

    always_comb
    begin
        ox_ext  = qcr_pkg::ERR_W'(ox_reg);
        oy_ext  = qcr_pkg::ERR_W'(oy_reg);
        y_step  = (err_reg <= oy_ext);
        oy1     = y_step ? (oy_reg + qcr_pkg::OFS_W'(1)) : oy_reg;
        oy1_ext = qcr_pkg::ERR_W'(oy1);
        err1    = y_step ? (err_reg + (oy1_ext <<< 1) + qcr_pkg::ERR_W'(1)) : err_reg;
        x_step  = (err_reg > ox_ext) || (err1 > oy1_ext);
        ox1     = x_step ? (ox_reg + qcr_pkg::OFS_W'(1)) : ox_reg;
        ox1_ext = qcr_pkg::ERR_W'(ox1);
        err2    = x_step ? (err1 + (ox1_ext <<< 1) + qcr_pkg::ERR_W'(1)) : err1;
    end

    always_comb
    begin
        err_next = err_reg;
        ox_next  = ox_reg;
        oy_next  = oy_reg;
        if (ctrl.load)
        begin
            ox_next  = qcr_pkg::OFS_W'(0) - signed'({1'b0, radius_sat});
            oy_next  = '0;
            err_next = qcr_pkg::ERR_W'(2)
                     - signed'(qcr_pkg::ERR_W'({radius_sat, 1'b0}));
        end
        else if (ctrl.advance)
        begin
            err_next = err2;
            ox_next  = ox1;
            oy_next  = oy1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_reg <= '0;
            ox_reg  <= '0;
            oy_reg  <= '0;
        end
        else
        begin
            err_reg <= err_next;
            ox_reg  <= ox_next;
            oy_reg  <= oy_next;
        end
    end

    assign offset_x  = ox_reg;
    assign offset_y  = oy_reg;
    assign step_done = ~ox1[qcr_pkg::OFS_W-1];

endmodule

// File: rtl/core/qcr_plot.sv
// ----------------------------------------------------------------------------
// qcr_plot
// Quadrant mapping of the walk offset around the center and frame bounds test.
// ----------------------------------------------------------------------------
module qcr_plot
#(
    parameter int COORD_BITS = 11
)
(
    input  logic        [COORD_BITS-1:0]         center_x,
    input  logic        [COORD_BITS-1:0]         center_y,
    input  qcr_pkg::quarter_t                    quarter,
    input  logic signed [qcr_pkg::OFS_W-1:0]     offset_x,
    input  logic signed [qcr_pkg::OFS_W-1:0]     offset_y,
    input  logic        [qcr_pkg::FRAME_W-1:0]   frame_width,
    input  logic        [qcr_pkg::FRAME_W-1:0]   frame_height,
    output logic        [qcr_pkg::PIX_W-1:0]     pixel_x,
    output logic        [qcr_pkg::PIX_W-1:0]     pixel_y,
    output logic                                 visible
);

    localparam int CW = COORD_BITS + 2;
    localparam int W  = (CW > qcr_pkg::PIX_W) ? CW : qcr_pkg::PIX_W;

    logic signed [W-1:0] cx_s, cy_s, ox_s, oy_s, fw_s, fh_s, px, py;

    always_comb
    begin
        cx_s = signed'(W'(center_x));
        cy_s = signed'(W'(center_y));
        ox_s = W'(offset_x);
        oy_s = W'(offset_y);
        fw_s = signed'(W'(frame_width));
        fh_s = signed'(W'(frame_height));
        case (quarter)
            qcr_pkg::QTR_NEG_X:
            begin
                px = cx_s - ox_s;
                py = cy_s + oy_s;
            end
            qcr_pkg::QTR_NEG_Y:
            begin
                px = cx_s - oy_s;
                py = cy_s - ox_s;
            end
            qcr_pkg::QTR_POS_X:
            begin
                px = cx_s + ox_s;
                py = cy_s - oy_s;
            end
            default:
            begin
                px = cx_s + oy_s;
                py = cy_s + ox_s;
            end
        endcase
        visible = ~px[W-1] && ~py[W-1] && (px < fw_s) && (py < fh_s);
    end

    assign pixel_x = px[qcr_pkg::PIX_W-1:0];
    assign pixel_y = py[qcr_pkg::PIX_W-1:0];

endmodule
